>>> rtl/lgcl_pkg.sv
`default_nettype none

package lgcl_pkg;

    // Board geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int WORD_W   = 64;
    localparam int CFG_W    = 7;
    localparam int CNT_W    = 4;

    // Stream payload widths (packed, padded to whole bytes)
    localparam int IN_FIELDS_W  = ROW_W + WORD_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ROW_W + COL_W + 1 + 1 + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Life rule constants
    localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
    localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_N,
        ST_READ_R,
        ST_READ_S,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Control into one row shifter
    typedef struct packed {
        logic load;
        logic shift;
        logic last_col;
    } shift_ctl_t;

    // West, center and east cell of one row at the current column
    typedef struct packed {
        logic west;
        logic center;
        logic east;
    } taps_t;

    // Outcome for the current column
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             old_state;
        logic             new_state;
        logic             changed;
    } eval_t;

endpackage

`default_nettype wire

>>> rtl/life_generation_change_list.sv
`default_nettype none

// Toroidal Life row evaluator with a change list. A load request (tuser 0)
// writes one 64-bit row word and gives no result. An evaluate request
// (tuser 1) reads the north, own and south rows one after another from the
// single read port of the board memory, then scans one column per cycle
// while the result side does not stall. Each changed cell is reported in
// ascending column order with tuser 1; tlast marks the final one. A row
// without change gives one marker with tuser 0 and tlast 1. The input side
// takes one request at a time and takes the next while the final result
// still waits. Rows must be loaded before they are evaluated; row_count and
// col_count are to be written only while the block is idle, and the block
// itself does not enforce this.
module life_generation_change_list (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Configuration writes
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [lgcl_pkg::CFG_W-1:0]        cfg_data,
    // Request stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lgcl_pkg::IN_DATA_W-1:0]    s_tdata,   // row_index[5:0], row_bits[69:6]
    input  wire logic                              s_tuser,   // command
    // Result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lgcl_pkg::OUT_DATA_W-1:0]        m_tdata,   // cell_row[5:0], cell_col[11:6],
                                                              // old_state[12], new_state[13],
                                                              // live_neighbors[17:14]
    output logic                                   m_tuser,   // changed
    output logic                                   m_tlast    // last
);

    localparam int ROW_W  = lgcl_pkg::ROW_W;
    localparam int COL_W  = lgcl_pkg::COL_W;
    localparam int CFG_W  = lgcl_pkg::CFG_W;
    localparam int CNT_W  = lgcl_pkg::CNT_W;
    localparam int WORD_W = lgcl_pkg::WORD_W;

    lgcl_pkg::state_t state_reg, state_next;

    logic [CFG_W-1:0] rc_reg, cc_reg;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [COL_W-1:0] pend_col_reg, pend_col_next;
    logic             pend_old_reg, pend_old_next;
    logic             pend_new_reg, pend_new_next;
    logic [CNT_W-1:0] pend_cnt_reg, pend_cnt_next;

    logic             m_valid_reg, m_valid_next;
    logic [ROW_W-1:0] m_row_reg, m_row_next;
    logic [COL_W-1:0] m_col_reg, m_col_next;
    logic             m_old_reg, m_old_next;
    logic             m_new_reg, m_new_next;
    logic [CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic             m_changed_reg, m_changed_next;
    logic             m_last_reg, m_last_next;

    logic [ROW_W-1:0]  in_row;
    logic [WORD_W-1:0] in_bits;
    logic              in_accept;

    logic [CFG_W-1:0] nrows;
    logic [ROW_W-1:0] nrows_m1;
    logic [COL_W-1:0] ncols_m1;
    logic [ROW_W-1:0] north_row, south_row;
    logic             row_in_range;

    logic              ram_we;
    logic [ROW_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    lgcl_pkg::shift_ctl_t ctl_n, ctl_r, ctl_s;
    lgcl_pkg::taps_t      taps_n, taps_r, taps_s;
    lgcl_pkg::eval_t      eval;

    logic last_col;
    logic can_step;

    assign in_row    = s_tdata[ROW_W-1:0];
    assign in_bits   = s_tdata[ROW_W+WORD_W-1:ROW_W];
    assign in_accept = s_tvalid && s_tready;

    // Effective board size: zero acts as one, large values clamp
    always_comb begin
        if (rc_reg == '0) begin
            nrows = CFG_W'(1);
        end else if (rc_reg > CFG_W'(lgcl_pkg::MAX_ROWS)) begin
            nrows = CFG_W'(lgcl_pkg::MAX_ROWS);
        end else begin
            nrows = rc_reg;
        end
        if (cc_reg == '0) begin
            ncols_m1 = '0;
        end else if (cc_reg > CFG_W'(lgcl_pkg::MAX_COLS)) begin
            ncols_m1 = COL_W'(lgcl_pkg::MAX_COLS - 1);
        end else begin
            ncols_m1 = COL_W'(cc_reg - CFG_W'(1));
        end
    end

    assign nrows_m1     = ROW_W'(nrows - CFG_W'(1));
    assign north_row    = (row_reg == '0) ? nrows_m1 : row_reg - ROW_W'(1);
    assign south_row    = (row_reg == nrows_m1) ? '0 : row_reg + ROW_W'(1);
    assign row_in_range = {1'b0, in_row} < nrows;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= CFG_W'(64);
            cc_reg <= CFG_W'(64);
        end else if (cfg_we) begin
            case (cfg_index)
                lgcl_pkg::REG_ROW_COUNT: rc_reg <= cfg_data;
                lgcl_pkg::REG_COL_COUNT: cc_reg <= cfg_data;
                default:                 rc_reg <= rc_reg;
            endcase
        end
    end

    // Board memory: load writes, evaluate reads three rows in turn
    assign ram_we = in_accept && (s_tuser == lgcl_pkg::CMD_LOAD) && row_in_range;

    always_comb begin
        case (state_reg)
            lgcl_pkg::ST_READ_N: rd_addr = north_row;
            lgcl_pkg::ST_READ_S: rd_addr = south_row;
            default:             rd_addr = row_reg;
        endcase
    end

    lgcl_ram #(
        .WIDTH(WORD_W),
        .DEPTH(lgcl_pkg::MAX_ROWS)
    ) u_board (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(in_row),
        .wr_data(in_bits),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Row shifters, one column per scan step
    assign last_col = col_reg == ncols_m1;
    assign can_step = !m_valid_reg || m_tready;

    always_comb begin
        ctl_n.shift    = (state_reg == lgcl_pkg::ST_SCAN) && can_step;
        ctl_n.last_col = last_col;
        ctl_n.load     = state_reg == lgcl_pkg::ST_READ_R;
        ctl_r          = ctl_n;
        ctl_r.load     = state_reg == lgcl_pkg::ST_READ_S;
        ctl_s          = ctl_n;
        ctl_s.load     = state_reg == lgcl_pkg::ST_LOAD;
    end

    lgcl_row_shift u_north (
        .aclk     (aclk),
        .ctl      (ctl_n),
        .west_sel (ncols_m1),
        .load_data(rd_data),
        .taps     (taps_n)
    );

    lgcl_row_shift u_middle (
        .aclk     (aclk),
        .ctl      (ctl_r),
        .west_sel (ncols_m1),
        .load_data(rd_data),
        .taps     (taps_r)
    );

    lgcl_row_shift u_south (
        .aclk     (aclk),
        .ctl      (ctl_s),
        .west_sel (ncols_m1),
        .load_data(rd_data),
        .taps     (taps_s)
    );

    lgcl_cell_eval u_eval (
        .north (taps_n),
        .middle(taps_r),
        .south (taps_s),
        .result(eval)
    );

    // State and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lgcl_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        row_reg        <= row_next;
        col_reg        <= col_next;
        pend_col_reg   <= pend_col_next;
        pend_old_reg   <= pend_old_next;
        pend_new_reg   <= pend_new_next;
        pend_cnt_reg   <= pend_cnt_next;
        m_row_reg      <= m_row_next;
        m_col_reg      <= m_col_next;
        m_old_reg      <= m_old_next;
        m_new_reg      <= m_new_next;
        m_cnt_reg      <= m_cnt_next;
        m_changed_reg  <= m_changed_next;
        m_last_reg     <= m_last_next;
    end

    // Next state; a found change waits in the pending slot until the next
    // one (or the end of the row) tells whether it is the last
    always_comb begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        pend_valid_next = pend_valid_reg;
        pend_col_next   = pend_col_reg;
        pend_old_next   = pend_old_reg;
        pend_new_next   = pend_new_reg;
        pend_cnt_next   = pend_cnt_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_row_next      = m_row_reg;
        m_col_next      = m_col_reg;
        m_old_next      = m_old_reg;
        m_new_next      = m_new_reg;
        m_cnt_next      = m_cnt_reg;
        m_changed_next  = m_changed_reg;
        m_last_next     = m_last_reg;
        s_tready        = 1'b0;

        case (state_reg)
            lgcl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (in_accept && (s_tuser == lgcl_pkg::CMD_EVAL)) begin
                    row_next   = in_row;
                    col_next   = '0;
                    state_next = row_in_range ? lgcl_pkg::ST_READ_N : lgcl_pkg::ST_DONE;
                end
            end
            lgcl_pkg::ST_READ_N: state_next = lgcl_pkg::ST_READ_R;
            lgcl_pkg::ST_READ_R: state_next = lgcl_pkg::ST_READ_S;
            lgcl_pkg::ST_READ_S: state_next = lgcl_pkg::ST_LOAD;
            lgcl_pkg::ST_LOAD:   state_next = lgcl_pkg::ST_SCAN;
            lgcl_pkg::ST_SCAN: begin
                if (can_step) begin
                    if (eval.changed) begin
                        if (pend_valid_reg) begin
                            m_valid_next   = 1'b1;
                            m_row_next     = row_reg;
                            m_col_next     = pend_col_reg;
                            m_old_next     = pend_old_reg;
                            m_new_next     = pend_new_reg;
                            m_cnt_next     = pend_cnt_reg;
                            m_changed_next = 1'b1;
                            m_last_next    = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_col_next   = col_reg;
                        pend_old_next   = eval.old_state;
                        pend_new_next   = eval.new_state;
                        pend_cnt_next   = eval.count;
                    end
                    col_next = col_reg + COL_W'(1);
                    if (last_col) begin
                        state_next = lgcl_pkg::ST_DONE;
                    end
                end
            end
            lgcl_pkg::ST_DONE: begin
                if (can_step) begin
                    m_valid_next    = 1'b1;
                    m_row_next      = row_reg;
                    m_last_next     = 1'b1;
                    m_changed_next  = pend_valid_reg;
                    m_col_next      = pend_valid_reg ? pend_col_reg : '0;
                    m_old_next      = pend_valid_reg && pend_old_reg;
                    m_new_next      = pend_valid_reg && pend_new_reg;
                    m_cnt_next      = pend_valid_reg ? pend_cnt_reg : '0;
                    pend_valid_next = 1'b0;
                    state_next      = lgcl_pkg::ST_IDLE;
                end
            end
            default: state_next = lgcl_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(lgcl_pkg::OUT_DATA_W - lgcl_pkg::OUT_FIELDS_W)'(0),
                       m_cnt_reg, m_new_reg, m_old_reg, m_col_reg, m_row_reg};
    assign m_tuser  = m_changed_reg;
    assign m_tlast  = m_last_reg;

    // No change entry is left over once a request has finished
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending change entry left in idle");

    // A no-change marker always closes its request
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("no-change marker without last");

    // A change entry really flips the cell
    a_entry_flips: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[12] != m_tdata[13]))
        else $error("change entry with equal old and new state");

    // The column scan never runs past the last column in use
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lgcl_pkg::ST_SCAN) |-> (col_reg <= ncols_m1))
        else $error("column scan past last column");

endmodule

`default_nettype wire

>>> rtl/lgcl_ram.sv
`default_nettype none

module lgcl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/lgcl_row_shift.sv
`default_nettype none

module lgcl_row_shift (
    input  wire logic                                aclk,
    input  wire lgcl_pkg::shift_ctl_t                ctl,
    input  wire logic [lgcl_pkg::COL_W-1:0]          west_sel,
    input  wire logic [lgcl_pkg::WORD_W-1:0]         load_data,
    output lgcl_pkg::taps_t                          taps
);

    logic [lgcl_pkg::WORD_W-1:0] word_reg;
    logic                        west_reg;
    logic                        first_reg;

    // Row word shifts right one column per step; column 0 comes first.
    // West of column 0 is the last column in use, east of the last is column 0.
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            word_reg  <= load_data;
            west_reg  <= load_data[west_sel];
            first_reg <= load_data[0];
        end else if (ctl.shift) begin
            word_reg  <= {1'b0, word_reg[lgcl_pkg::WORD_W-1:1]};
            west_reg  <= word_reg[0];
        end
    end

    assign taps.west   = west_reg;
    assign taps.center = word_reg[0];
    assign taps.east   = ctl.last_col ? first_reg : word_reg[1];

endmodule

`default_nettype wire

>>> rtl/lgcl_cell_eval.sv
`default_nettype none

module lgcl_cell_eval (
    input  wire lgcl_pkg::taps_t north,
    input  wire lgcl_pkg::taps_t middle,
    input  wire lgcl_pkg::taps_t south,
    output lgcl_pkg::eval_t      result
);

    logic [lgcl_pkg::CNT_W-1:0] count;
    logic                       next_state;

    // Eight-neighbor count, center of the middle row excluded
    assign count = {3'b000, north.west}  + {3'b000, north.center} + {3'b000, north.east}
                 + {3'b000, middle.west} + {3'b000, middle.east}
                 + {3'b000, south.west}  + {3'b000, south.center} + {3'b000, south.east};

    // Birth on three, survival on two or three
    assign next_state = (count == lgcl_pkg::BIRTH_COUNT)
                     || ((count == lgcl_pkg::SURVIVE_COUNT) && middle.center);

    assign result.count     = count;
    assign result.old_state = middle.center;
    assign result.new_state = next_state;
    assign result.changed   = next_state != middle.center;

endmodule

`default_nettype wire
